/* design/bms_pkg.sv */
// Shared types and constants for the bus message serializer.
`default_nettype none
package bms_pkg;

    localparam int unsigned IN_TDATA_W  = 112;
    localparam int unsigned OUT_TDATA_W = 8;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic [31:0] word2;
        logic [31:0] word1;
        logic [31:0] word0;
        logic [1:0]  length_code;
        logic [7:0]  prefix;
    } t_item;

    typedef struct packed {
        logic final_state;
        logic data_pin;
        logic clock_pin;
    } t_result;

endpackage
`default_nettype wire

/* design/bms_core.sv */
// Message sequencer: segment, bit and half-phase state with pin state decode.
`default_nettype none
module bms_core #(
    parameter int unsigned INTERJECTION_TOGGLES = 6,
    parameter int unsigned ARBITRATION_BITS     = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_operation,
    input  wire bms_pkg::t_item   i_item,
    output logic                  o_res_valid,
    output bms_pkg::t_result      o_res
);
    import bms_pkg::*;

    localparam logic [2:0] SEG_IDLE   = 3'd0;
    localparam logic [2:0] SEG_PULL   = 3'd1;
    localparam logic [2:0] SEG_ARB    = 3'd2;
    localparam logic [2:0] SEG_PREFIX = 3'd3;
    localparam logic [2:0] SEG_DATA   = 3'd4;
    localparam logic [2:0] SEG_INTJ   = 3'd5;
    localparam logic [2:0] SEG_TAIL   = 3'd6;

    localparam logic [6:0] ARB_LAST  = 7'(ARBITRATION_BITS - 1);
    localparam logic [6:0] INTJ_LAST = 7'(INTERJECTION_TOGGLES - 1);

    logic [2:0]  r_seg,    n_seg;
    logic [6:0]  r_cnt,    n_cnt;
    logic        r_half,   n_half;
    logic [95:0] r_shift,  n_shift;
    logic [7:0]  r_prefix, n_prefix;
    logic        r_tail,   n_tail;
    logic [1:0]  r_len,    n_len;
    logic [6:0]  seg_last;

    always_comb begin
        case (r_seg)
            SEG_ARB:    seg_last = ARB_LAST;
            SEG_PREFIX: seg_last = 7'd7;
            SEG_DATA: begin
                case (r_len)
                    2'd0:    seg_last = 7'd7;
                    2'd1:    seg_last = 7'd31;
                    2'd2:    seg_last = 7'd63;
                    default: seg_last = 7'd95;
                endcase
            end
            SEG_INTJ:   seg_last = INTJ_LAST;
            SEG_TAIL:   seg_last = 7'd3;
            default:    seg_last = 7'd0;
        endcase
    end

    always_comb begin
        n_seg       = r_seg;
        n_cnt       = r_cnt;
        n_half      = r_half;
        n_shift     = r_shift;
        n_prefix    = r_prefix;
        n_tail      = r_tail;
        n_len       = r_len;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_valid) begin
            if (i_operation == OP_START) begin
                n_prefix = i_item.prefix;
                n_len    = i_item.length_code;
                n_shift  = {i_item.word0, i_item.word1, i_item.word2};
                n_tail   = i_item.word0[0];
                n_seg    = SEG_PULL;
                n_cnt    = '0;
                n_half   = 1'b0;
            end else begin
                case (r_seg)
                    SEG_PULL: begin
                        o_res_valid       = 1'b1;
                        o_res.clock_pin   = 1'b1;
                        o_res.data_pin    = 1'b0;
                        n_seg             = SEG_ARB;
                        n_cnt             = '0;
                        n_half            = 1'b0;
                    end
                    SEG_ARB, SEG_PREFIX, SEG_DATA, SEG_INTJ, SEG_TAIL: begin
                        o_res_valid = 1'b1;
                        o_res.clock_pin = (r_seg == SEG_INTJ) ? 1'b1 : r_half;
                        case (r_seg)
                            SEG_PREFIX: o_res.data_pin = r_prefix[7];
                            SEG_DATA:   o_res.data_pin = r_shift[95];
                            SEG_INTJ:   o_res.data_pin = r_half;
                            SEG_TAIL:   o_res.data_pin = (r_cnt == 7'd0) ? r_tail : 1'b1;
                            default:    o_res.data_pin = 1'b0;
                        endcase
                        if (!r_half) begin
                            n_half = 1'b1;
                        end else begin
                            n_half = 1'b0;
                            if (r_seg == SEG_PREFIX) begin
                                n_prefix = {r_prefix[6:0], 1'b0};
                            end
                            if (r_seg == SEG_DATA) begin
                                n_shift = {r_shift[94:0], 1'b0};
                            end
                            if (r_cnt == seg_last) begin
                                n_cnt = '0;
                                if (r_seg == SEG_TAIL) begin
                                    o_res.final_state = 1'b1;
                                    n_seg             = SEG_IDLE;
                                end else begin
                                    n_seg = r_seg + 3'd1;
                                end
                            end else begin
                                n_cnt = r_cnt + 7'd1;
                            end
                        end
                    end
                    default: begin
                        o_res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg    <= SEG_IDLE;
            r_cnt    <= '0;
            r_half   <= 1'b0;
            r_shift  <= '0;
            r_prefix <= '0;
            r_tail   <= 1'b0;
            r_len    <= '0;
        end else begin
            r_seg    <= n_seg;
            r_cnt    <= n_cnt;
            r_half   <= n_half;
            r_shift  <= n_shift;
            r_prefix <= n_prefix;
            r_tail   <= n_tail;
            r_len    <= n_len;
        end
    end

endmodule
`default_nettype wire

/* design/bms_out_buf.sv */
// Two-entry result buffer that decouples the sequencer from the output stall.
`default_nettype none
module bms_out_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire bms_pkg::t_result i_res,
    output logic                  o_room,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output bms_pkg::t_result      o_res
);
    import bms_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_room  = (r_count != 2'd2);
    assign o_res   = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

/* design/bus_message_serializer_unit.sv */
// Top level of the bus message serializer.
//
// Input stream: each word is a start (tuser = 0) that loads the prefix,
// length code and three data words, or a tick (tuser = 1) that advances the
// bus by one pin state. Output stream: one word per tick while a message is
// in progress, carrying the clock and data pin levels; tlast marks the last
// pin state of the message. Starts and ticks while idle produce no word.
// A start during a message abandons it and loads the new one.
//
// A pin state word is registered into the output buffer when its tick is
// taken. Throughput: one input word per cycle while the output buffer has
// room; the sequencer state updates in the cycle the word is taken, so
// back-to-back ticks run freely. A two-entry output buffer holds results
// while the receiver stalls; input tready drops only when both entries are full.
//
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the output buffer.
`default_nettype none
module bus_message_serializer_unit #(
    parameter int unsigned INTERJECTION_TOGGLES = 6,
    parameter int unsigned ARBITRATION_BITS     = 3
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // prefix[7:0], length_code[9:8], word0[41:10], word1[73:42],
    // word2[105:74], zero[111:106]
    input  wire logic [bms_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // operation[0]
    input  wire logic                             i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // clock_pin[0], data_pin[1], zero[7:2]
    output logic [bms_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    // final_state
    output logic                                  o_m_axis_tlast
);
    import bms_pkg::*;

    logic    in_accept;
    logic    res_valid;
    t_result res;
    t_result out_res;
    t_item   item;
    logic    room;

    assign item            = t_item'(i_s_axis_tdata[$bits(t_item)-1:0]);
    assign o_s_axis_tready = room;
    assign in_accept       = i_s_axis_tvalid && room;

    bms_core #(
        .INTERJECTION_TOGGLES (INTERJECTION_TOGGLES),
        .ARBITRATION_BITS     (ARBITRATION_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_accept),
        .i_operation (i_s_axis_tuser),
        .i_item      (item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bms_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (out_res)
    );

    assign o_m_axis_tdata = {6'b0, out_res.data_pin, out_res.clock_pin};
    assign o_m_axis_tlast = out_res.final_state;

endmodule
`default_nettype wire

/* design/bms_checker.sv */
// Port-level checker for the bus message serializer, bound to the top level.
`default_nettype none
module bms_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_axis_tvalid,
    input wire logic       o_s_axis_tready,
    input wire logic       i_s_axis_tuser,
    input wire logic       o_m_axis_tvalid,
    input wire logic       i_m_axis_tready,
    input wire logic [7:0] o_m_axis_tdata,
    input wire logic       o_m_axis_tlast
);
    import bms_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output word changed");

    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == OP_START)
            && !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("start word produced a result");

    a_last_clock_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tdata[0])
        else $error("final pin state with clock low");

    a_full_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with no pending output");

endmodule

bind bus_message_serializer_unit bms_checker u_bms_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
`default_nettype wire

/* tb/bus_message_pin_checker.sv */
// Checker that predicts serializer pin states from accepted input words and compares them.
module bus_message_pin_checker #(
    parameter int unsigned INTERJECTION_TOGGLES = 6,
    parameter int unsigned ARBITRATION_BITS     = 3
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    input  wire logic                               i_s_axis_tready,
    // prefix[7:0], length_code[9:8], word0[41:10], word1[73:42],
    // word2[105:74], zero[111:106]
    input  wire logic [bms_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // operation[0]
    input  wire logic                               i_s_axis_tuser,
    input  wire logic                               i_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // clock_pin[0], data_pin[1], zero[7:2]
    input  wire logic [bms_pkg::OUT_TDATA_W-1:0]    i_m_axis_tdata,
    // final_state
    input  wire logic                               i_m_axis_tlast,
    output int                                      o_fail_count,
    output int                                      o_pending,
    output int                                      o_checked
);
    import bms_pkg::*;

    localparam int MAX_PRINTED = 30;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PULL,
        PH_ARB,
        PH_PREFIX,
        PH_DATA,
        PH_INTJ,
        PH_TAIL
    } t_phase;

    t_phase      phase;
    logic [6:0]  bit_idx;
    logic        half;
    logic [95:0] data_bits;
    logic [7:0]  prefix_bits;
    logic        tail_bit;
    logic [1:0]  len_code;
    t_result     pin_queue[$];
    int          fail_count;
    int          checked_count;

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_checked     = 0;
        fail_count    = 0;
        checked_count = 0;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTED) begin
            $display("mismatch %0d at %0t: %s", fail_count, $realtime, msg);
        end
    endtask

    function automatic int unsigned phase_bits(input t_phase p);
        case (p)
            PH_ARB:    return ARBITRATION_BITS;
            PH_PREFIX: return 8;
            PH_DATA:   return (len_code == 2'd0) ? 8 : 32 * len_code;
            PH_INTJ:   return INTERJECTION_TOGGLES;
            PH_TAIL:   return 4;
            default:   return 1;
        endcase
    endfunction

    function automatic logic phase_bit(input t_phase p, input logic [6:0] idx);
        case (p)
            PH_PREFIX: return (idx < 8) ? prefix_bits[7 - idx] : 1'b0;
            PH_DATA:   return (idx < 96) ? data_bits[95 - idx] : 1'b0;
            PH_TAIL:   return (idx == 0) ? tail_bit : 1'b1;
            default:   return 1'b0;
        endcase
    endfunction

    task automatic step_pins(input logic op, input t_item fields);
        t_result pins;
        if (op == OP_START) begin
            prefix_bits = fields.prefix;
            len_code    = fields.length_code;
            data_bits   = {fields.word0, fields.word1, fields.word2};
            tail_bit    = fields.word0[0];
            phase       = PH_PULL;
            bit_idx     = '0;
            half        = 1'b0;
        end else if (phase != PH_IDLE) begin
            pins = '0;
            if (phase == PH_PULL) begin
                pins.clock_pin = 1'b1;
                pins.data_pin  = 1'b0;
                phase          = PH_ARB;
                bit_idx        = '0;
                half           = 1'b0;
            end else begin
                if (phase == PH_INTJ) begin
                    pins.clock_pin = 1'b1;
                    pins.data_pin  = half;
                end else begin
                    pins.clock_pin = half;
                    pins.data_pin  = phase_bit(phase, bit_idx);
                end
                if (!half) begin
                    half = 1'b1;
                end else begin
                    half    = 1'b0;
                    bit_idx = bit_idx + 7'd1;
                    if (bit_idx >= phase_bits(phase)) begin
                        bit_idx = '0;
                        if (phase == PH_TAIL) begin
                            pins.final_state = 1'b1;
                            phase            = PH_IDLE;
                        end else begin
                            phase = t_phase'(phase + 3'd1);
                        end
                    end
                end
            end
            pin_queue.push_back(pins);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            phase       = PH_IDLE;
            bit_idx     = '0;
            half        = 1'b0;
            data_bits   = '0;
            prefix_bits = '0;
            tail_bit    = 1'b0;
            len_code    = '0;
            pin_queue.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.clock_pin   = i_m_axis_tdata[0];
                got.data_pin    = i_m_axis_tdata[1];
                got.final_state = i_m_axis_tlast;
                if (pin_queue.size() == 0) begin
                    report_mismatch($sformatf("pin state word %b/%b/%b with nothing pending",
                                              got.clock_pin, got.data_pin, got.final_state));
                end else begin
                    want = pin_queue.pop_front();
                    checked_count++;
                    if (got.clock_pin !== want.clock_pin) begin
                        report_mismatch($sformatf("clock_pin expected %b got %b",
                                                  want.clock_pin, got.clock_pin));
                    end
                    if (got.data_pin !== want.data_pin) begin
                        report_mismatch($sformatf("data_pin expected %b got %b",
                                                  want.data_pin, got.data_pin));
                    end
                    if (got.final_state !== want.final_state) begin
                        report_mismatch($sformatf("final_state expected %b got %b",
                                                  want.final_state, got.final_state));
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                step_pins(i_s_axis_tuser, t_item'(i_s_axis_tdata[$bits(t_item)-1:0]));
            end
        end
        o_pending    <= pin_queue.size();
        o_fail_count <= fail_count;
        o_checked    <= checked_count;
    end

endmodule

/* tb/bus_message_serializer_unit_tb.sv */
// Testbench top: drives start and tick words into the serializer and gives the verdict.
module bus_message_serializer_unit_tb;
    import bms_pkg::*;

    localparam int unsigned TOGGLES     = 6;
    localparam int unsigned ARB_BITS    = 3;
    localparam int unsigned ITEM_GOAL   = 1800;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned NO_CUT      = 32'hFFFF_FFFF;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                   i_s_axis_tuser  = OP_TICK;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;

    int          fail_count;
    int          pending;
    int          checked;
    int unsigned idle_cycles = 0;
    int unsigned words_sent  = 0;
    int unsigned busy_words  = 0;
    int unsigned messages    = 0;
    int unsigned abandoned   = 0;
    bit          steady      = 1'b0;

    bus_message_serializer_unit #(
        .INTERJECTION_TOGGLES(TOGGLES),
        .ARBITRATION_BITS    (ARB_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    bus_message_pin_checker #(
        .INTERJECTION_TOGGLES(TOGGLES),
        .ARBITRATION_BITS    (ARB_BITS)
    ) pin_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .i_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .i_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .i_m_axis_tdata (o_m_axis_tdata),
        .i_m_axis_tlast (o_m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_item make_item(input logic [7:0] prefix, input logic [1:0] len,
                                        input logic [31:0] w0, input logic [31:0] w1,
                                        input logic [31:0] w2);
        t_item f;
        f.prefix      = prefix;
        f.length_code = len;
        f.word0       = w0;
        f.word1       = w1;
        f.word2       = w2;
        return f;
    endfunction

    function automatic t_item rand_item();
        int unsigned r;
        logic [1:0]  len;
        r   = $urandom_range(0, 19);
        len = (r < 7) ? 2'd0 : (r < 14) ? 2'd1 : (r < 17) ? 2'd2 : 2'd3;
        return make_item(8'($urandom), len, $urandom, $urandom, $urandom);
    endfunction

    // hold the word until taken, then idle for a random gap (none in steady mode)
    task automatic send_word(input logic op, input t_item fields);
        int unsigned gap;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= IN_TDATA_W'(fields);
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        words_sent++;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // send a start and its ticks; stop after cut ticks to leave it abandoned
    task automatic run_message(input t_item fields, input int unsigned cut);
        int unsigned states;
        int unsigned nbits;
        nbits  = (fields.length_code == 2'd0) ? 8 : 32 * fields.length_code;
        states = 1 + 2 * (ARB_BITS + 8 + nbits + TOGGLES + 4);
        send_word(OP_START, fields);
        busy_words++;
        for (int unsigned k = 0; k < states && k < cut; k++) begin
            send_word(OP_TICK, rand_item());
            busy_words++;
        end
        messages++;
        if (cut < states) abandoned++;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : sink_ready
        int unsigned run_len;
        int unsigned hold;
        @(posedge i_clk);
        forever begin
            i_m_axis_tready <= 1'b1;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                  : $urandom_range(1, 12);
            repeat (run_len) @(posedge i_clk);
            hold = pick_gap();
            if (hold != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int unsigned r;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ticks with no message in progress
        send_word(OP_TICK, rand_item());
        send_word(OP_TICK, make_item('1, '1, '1, '1, '1));
        // 8-bit mode, tail bit taken from word0 bit 0
        run_message(make_item(8'h00, 2'd0, 32'hFF00_0001, '1, '1), NO_CUT);
        run_message(make_item(8'hFF, 2'd0, 32'h00FF_FFFE, '0, '0), NO_CUT);
        wait_drained();
        run_message(make_item(8'hA5, 2'd1, '1, '0, '0), NO_CUT);
        // abandon a long message, then a start right after a start
        run_message(make_item(8'hFF, 2'd3, '1, '1, '1), 40);
        run_message(make_item(8'h5A, 2'd2, '0, '1, '0), 0);
        run_message(make_item(8'h00, 2'd2, '0, '0, '1), NO_CUT);
        run_message(make_item(8'h81, 2'd3, '0, '1, 32'h5A5A_A5A5), NO_CUT);
        send_word(OP_TICK, make_item('0, '0, '0, '0, '0));
        wait_drained();

        while (busy_words < ITEM_GOAL) begin
            steady = ($urandom_range(0, 3) == 0);
            r      = $urandom_range(0, 99);
            if (r < 80) begin
                run_message(rand_item(), NO_CUT);
            end else if (r < 92) begin
                run_message(rand_item(), $urandom_range(0, 60));
            end else begin
                repeat ($urandom_range(1, 4)) send_word(OP_TICK, rand_item());
            end
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
        steady = 1'b0;

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("covered %0d messages (%0d cut short by a new start) in %0d input words",
                 messages, abandoned, words_sent);
        $display("compared %0d pin states, %0d mismatches", checked, fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
